@@ sv/npss_pkg.sv @@
// Shared types, constants and helper functions of the nearest-point snap store.
package npss_pkg;

  // Store geometry
  localparam int POINTS_PER_CATEGORY = 1024;
  localparam int COORD_BITS          = 24;
  localparam int NUM_CAT             = 3;

  // Field widths
  localparam int FIELD_W   = 24;
  localparam int COORD_W   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int HIT_IDX_W = 10;
  localparam int IDX_W     = (POINTS_PER_CATEGORY > 1) ? $clog2(POINTS_PER_CATEGORY) : 1;
  localparam int CNT_W     = $clog2(POINTS_PER_CATEGORY + 1);
  localparam int MEM_DEPTH = NUM_CAT * POINTS_PER_CATEGORY;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Distance arithmetic widths
  localparam int DIFF_W = FIELD_W + 1;
  localparam int SQ_W   = 2 * FIELD_W;
  localparam int SUM_W  = SQ_W + 2;

  // Action codes
  localparam logic [1:0] ACT_STORE = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_SET   = 2'd2;

  // Category codes
  localparam logic [1:0] CAT_FLOOR  = 2'd0;
  localparam logic [1:0] CAT_SCREEN = 2'd1;
  localparam logic [1:0] CAT_BALL   = 2'd2;

  // Result status codes
  localparam logic [2:0] STS_STORED  = 3'd0;
  localparam logic [2:0] STS_DROPPED = 3'd1;
  localparam logic [2:0] STS_SET     = 3'd2;
  localparam logic [2:0] STS_HIT     = 3'd3;
  localparam logic [2:0] STS_MISS    = 3'd4;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic        [1:0]         action;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic        [FIELD_W-1:0] pick_radius;
    logic        [1:0]         new_category;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]           status;
    logic        [1:0]           hit_category;
    logic        [HIT_IDX_W-1:0] hit_index;
    logic signed [FIELD_W-1:0]   snap_x;
    logic signed [FIELD_W-1:0]   snap_y;
    logic signed [FIELD_W-1:0]   snap_z;
  } out_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [CNT_W-1:0] floor_cnt;
    logic [CNT_W-1:0] screen_cnt;
    logic [CNT_W-1:0] ball_cnt;
  } counts_t;

  typedef struct packed {
    logic             hit;
    logic [1:0]       cat;
    logic [IDX_W-1:0] idx;
    point_t           pt;
  } scan_res_t;

  // Sign-extend the low COORD_W bits of a raw coordinate field
  function automatic logic signed [FIELD_W-1:0] coord_in(input logic [FIELD_W-1:0] raw);
    logic signed [COORD_W-1:0] v;
    v = raw[COORD_W-1:0];
    return FIELD_W'(v);
  endfunction

  // Fill count of one category store
  function automatic logic [CNT_W-1:0] count_of(input counts_t c, input logic [1:0] cat);
    logic [CNT_W-1:0] n;
    unique case (cat)
      CAT_SCREEN: n = c.screen_cnt;
      CAT_BALL:   n = c.ball_cnt;
      default:    n = c.floor_cnt;
    endcase
    return n;
  endfunction

  // Memory address of an entry: category block, then index within it
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [1:0] cat,
                                                 input logic [IDX_W-1:0] idx);
    return ADDR_W'(cat) * ADDR_W'(POINTS_PER_CATEGORY) + ADDR_W'(idx);
  endfunction

endpackage

@@ sv/npss_if.sv @@
// Valid/ready channel interfaces for input transactions and result transactions.
interface npss_in_if
  import npss_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface npss_out_if
  import npss_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/npss_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module npss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/npss_scan.sv @@
// Query scan: walks the stores through the memory read port and tracks the nearest entry.
module npss_scan
  import npss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  point_t              qpt_i,
  input  logic [FIELD_W-1:0]  radius_i,
  input  counts_t             counts_i,
  output logic                rd_en_o,
  output logic [ADDR_W-1:0]   rd_addr_o,
  input  point_t              rd_data_i,
  output logic                done_o,
  output scan_res_t           res_o
);

  typedef struct packed {
    logic [1:0]       cat;
    logic [IDX_W-1:0] idx;
    point_t           pt;
  } entry_t;

  // Read sequencer
  logic             active_q;
  logic             issuing_q;
  logic [1:0]       cat_q;
  logic [CNT_W-1:0] idx_q;
  logic             issue;

  // Query operands
  point_t             qpt_q;
  logic [FIELD_W-1:0] radius_q;

  // Pipeline stages
  logic               v0_q, v1_q, v2_q, v3_q;
  logic [1:0]         cat0_q;
  logic [IDX_W-1:0]   idx0_q;
  entry_t             ent1_q, ent2_q, ent3_q;
  logic [FIELD_W-1:0] adx1_q, ady1_q, adz1_q;
  logic [SQ_W-1:0]    sqx2_q, sqy2_q, sqz2_q;
  logic [SUM_W-1:0]   sum3_q;

  // Best so far
  logic [SUM_W-1:0]   best_q;
  logic               hit_q;
  entry_t             best_ent_q;

  logic [DIFF_W-1:0]  adx, ady, adz;
  logic               reject;
  logic               pipe_busy;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [FIELD_W-1:0] a,
                                                 input logic signed [FIELD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  // Issue one read per cycle while the current store has entries left
  assign issue     = issuing_q && (idx_q < count_of(counts_i, cat_q));
  assign rd_en_o   = issue;
  assign rd_addr_o = mem_addr(cat_q, idx_q[IDX_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      issuing_q <= 1'b0;
      cat_q     <= CAT_FLOOR;
      idx_q     <= '0;
    end else if (start_i) begin
      active_q  <= 1'b1;
      issuing_q <= 1'b1;
      cat_q     <= CAT_FLOOR;
      idx_q     <= '0;
    end else begin
      if (done_o) begin
        active_q <= 1'b0;
      end
      if (issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end else if (issuing_q) begin
        if (cat_q == CAT_BALL) begin
          issuing_q <= 1'b0;
        end else begin
          cat_q <= cat_q + 2'd1;
          idx_q <= '0;
        end
      end
    end
  end

  // Latch query operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qpt_q    <= qpt_i;
      radius_q <= radius_i;
    end
  end

  // Component distances and early reject on read data
  always_comb begin
    adx    = abs_diff(rd_data_i.x, qpt_q.x);
    ady    = abs_diff(rd_data_i.y, qpt_q.y);
    adz    = abs_diff(rd_data_i.z, qpt_q.z);
    reject = (adx >= DIFF_W'(radius_q)) || (ady >= DIFF_W'(radius_q)) ||
             (adz >= DIFF_W'(radius_q));
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= issue;
      v1_q <= v0_q && !reject;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payload: tag, abs diffs, squares, sum
  always_ff @(posedge clk_i) begin
    cat0_q     <= cat_q;
    idx0_q     <= idx_q[IDX_W-1:0];
    ent1_q.cat <= cat0_q;
    ent1_q.idx <= idx0_q;
    ent1_q.pt  <= rd_data_i;
    adx1_q     <= adx[FIELD_W-1:0];
    ady1_q     <= ady[FIELD_W-1:0];
    adz1_q     <= adz[FIELD_W-1:0];
    ent2_q     <= ent1_q;
    sqx2_q     <= SQ_W'(adx1_q) * SQ_W'(adx1_q);
    sqy2_q     <= SQ_W'(ady1_q) * SQ_W'(ady1_q);
    sqz2_q     <= SQ_W'(adz1_q) * SQ_W'(adz1_q);
    ent3_q     <= ent2_q;
    sum3_q     <= SUM_W'(sqx2_q) + SUM_W'(sqy2_q) + SUM_W'(sqz2_q);
  end

  // Keep an entry only when it is strictly closer than the best so far; on a tie the earlier entry stays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (start_i) begin
      hit_q <= 1'b0;
    end else if (v3_q && (sum3_q < best_q)) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      best_q <= SUM_W'(SQ_W'(radius_i) * SQ_W'(radius_i));
    end else if (v3_q && (sum3_q < best_q)) begin
      best_q     <= sum3_q;
      best_ent_q <= ent3_q;
    end
  end

  assign pipe_busy = v0_q || v1_q || v2_q || v3_q;
  assign done_o    = active_q && !issuing_q && !pipe_busy && !start_i;

  // Result: picked entry, or the query point on a miss
  always_comb begin
    res_o.hit = hit_q;
    if (hit_q) begin
      res_o.cat = best_ent_q.cat;
      res_o.idx = best_ent_q.idx;
      res_o.pt  = best_ent_q.pt;
    end else begin
      res_o.cat = CAT_FLOOR;
      res_o.idx = '0;
      res_o.pt  = qpt_q;
    end
  end

endmodule

@@ sv/nearest_point_snap_store_core.sv @@
// Nearest-point snap store top level: store control, fill counts, query scan and result register.
// A store or set-category transaction writes its result into the result register, where it is
// ready the next cycle. A query reads every stored entry once through the single read port of
// the point memory, one entry per cycle within each store. The scan steps on from the floor to
// the screen to the ball store, passes the entries read through the distance pipeline, and hands
// the result into the result register. The next transaction is accepted once the query result
// has been placed in the output register. Results wait in that register, and a new transaction
// is accepted while the result register is free or is being emptied in the same cycle. The point
// memory needs no clearing after reset: only entries below each store's fill count are read.
module nearest_point_snap_store_core
  import npss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  npss_in_if.sink   in_i,
  npss_out_if.source out_o
);

  ctrl_state_e state_q, state_d;
  counts_t     counts_q, counts_d;
  logic [1:0]  cur_cat_q, cur_cat_d;

  logic        out_valid_q;
  out_item_t   out_data_q;
  logic        out_free;
  logic        out_load;
  out_item_t   out_next;

  logic        in_ready;
  logic        in_fire;
  point_t      in_pt;
  logic [CNT_W-1:0] cur_cnt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic              scan_start;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  point_t            rd_data;
  logic              scan_done;
  scan_res_t         scan_res;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_comb begin
    in_pt.x = coord_in(in_i.payload.pos_x);
    in_pt.y = coord_in(in_i.payload.pos_y);
    in_pt.z = coord_in(in_i.payload.pos_z);
  end

  assign cur_cnt = count_of(counts_q, cur_cat_q);
  assign waddr   = mem_addr(cur_cat_q, cur_cnt[IDX_W-1:0]);

  // Next state, counts, memory write and result selection
  always_comb begin
    state_d    = state_q;
    counts_d   = counts_q;
    cur_cat_d  = cur_cat_q;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    we         = 1'b0;
    scan_start = 1'b0;
    out_next.status       = STS_STORED;
    out_next.hit_category = cur_cat_q;
    out_next.hit_index    = '0;
    out_next.snap_x       = in_pt.x;
    out_next.snap_y       = in_pt.y;
    out_next.snap_z       = in_pt.z;

    unique case (state_q)
      CTRL_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          unique case (in_i.payload.action)
            ACT_STORE: begin
              out_load = 1'b1;
              if (cur_cnt >= CNT_W'(POINTS_PER_CATEGORY)) begin
                out_next.status = STS_DROPPED;
              end else begin
                we                 = 1'b1;
                out_next.hit_index = HIT_IDX_W'(cur_cnt[IDX_W-1:0]);
                unique case (cur_cat_q)
                  CAT_SCREEN: counts_d.screen_cnt = counts_q.screen_cnt + CNT_W'(1);
                  CAT_BALL:   counts_d.ball_cnt   = counts_q.ball_cnt + CNT_W'(1);
                  default:    counts_d.floor_cnt  = counts_q.floor_cnt + CNT_W'(1);
                endcase
              end
            end
            ACT_SET: begin
              out_load        = 1'b1;
              out_next.status = STS_SET;
              if (in_i.payload.new_category <= CAT_BALL) begin
                cur_cat_d             = in_i.payload.new_category;
                out_next.hit_category = in_i.payload.new_category;
                if (in_i.payload.new_category == CAT_SCREEN) begin
                  counts_d.screen_cnt = '0;
                end
              end
            end
            ACT_QUERY: begin
              scan_start = 1'b1;
              state_d    = CTRL_SCAN;
            end
            default: begin
              // drop a transaction without meaning
            end
          endcase
        end
      end
      CTRL_SCAN: begin
        if (scan_done) begin
          state_d = CTRL_DONE;
        end
      end
      CTRL_DONE: begin
        out_next.status       = scan_res.hit ? STS_HIT : STS_MISS;
        out_next.hit_category = scan_res.cat;
        out_next.hit_index    = HIT_IDX_W'(scan_res.idx);
        out_next.snap_x       = scan_res.pt.x;
        out_next.snap_y       = scan_res.pt.y;
        out_next.snap_z       = scan_res.pt.z;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      counts_q    <= '0;
      cur_cat_q   <= CAT_FLOOR;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      counts_q  <= counts_d;
      cur_cat_q <= cur_cat_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_next;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  npss_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MEM_DEPTH)
  ) u_point_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_pt),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  npss_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .qpt_i     (in_pt),
    .radius_i  (in_i.payload.pick_radius),
    .counts_i  (counts_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .done_o    (scan_done),
    .res_o     (scan_res)
  );

endmodule

@@ sv/npss_checker.sv @@
// Port-level checker for the nearest-point snap store, bound to the top level.
module npss_checker
  import npss_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic [1:0]           in_action_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [2:0]           out_status_i,
  input logic [1:0]           out_hit_category_i,
  input logic [HIT_IDX_W-1:0] out_hit_index_i
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_hit_category_i) && $stable(out_hit_index_i))
    else $error("stalled result transaction changed");

  // A miss carries no entry reference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STS_MISS) |->
      (out_hit_category_i == CAT_FLOOR) && (out_hit_index_i == '0))
    else $error("query miss with nonzero entry reference");

  // Store and set transactions answer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && ((in_action_i == ACT_STORE) || (in_action_i == ACT_SET))
      |=> out_valid_i)
    else $error("store or set transaction gave no result");

  // A query holds off new transactions while it scans
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_QUERY) |=> !in_ready_i)
    else $error("transaction accepted during a query scan");

endmodule

bind nearest_point_snap_store_core npss_checker u_npss_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_action_i        (in_i.payload.action),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_status_i       (out_o.payload.status),
  .out_hit_category_i (out_o.payload.hit_category),
  .out_hit_index_i    (out_o.payload.hit_index)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the nearest-point snap store: directed, backpressure and random tests.
module tb_top;
  import npss_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 50;

  localparam logic [1:0]         ACT_NONE   = 2'd3;
  localparam logic [1:0]         CAT_NONE   = 2'd3;
  localparam logic [FIELD_W-1:0] RADIUS_MAX = {FIELD_W{1'b1}};
  localparam int                 COORD_MAX  = 8388607;
  localparam int                 COORD_MIN  = -8388608;

  logic clk_i;
  logic rst_ni;

  npss_in_if  in_if ();
  npss_out_if out_if ();

  nearest_point_snap_store_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the three point stores
  point_t      shadow_points [NUM_CAT][POINTS_PER_CATEGORY];
  int unsigned shadow_fill   [NUM_CAT];
  logic [1:0]  shadow_cat;

  out_item_t   expected_results [$];
  out_item_t   want;
  int          mismatch_count;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          hold_request;
  int          hold_left;

  // Clock: 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one transaction to the shadow stores and work out the result it causes
  function automatic bit snap_predict(input in_item_t it, output out_item_t res);
    longint      qv [3];
    longint      ev [3];
    longint      r;
    longint      ad;
    longint      sum;
    longint      best;
    bit          hit;
    bit          reject;
    int unsigned slot;
    logic [1:0]  bcat;
    int unsigned bidx;
    res        = '0;
    res.snap_x = it.pos_x;
    res.snap_y = it.pos_y;
    res.snap_z = it.pos_z;
    qv[0]      = it.pos_x;
    qv[1]      = it.pos_y;
    qv[2]      = it.pos_z;
    r          = it.pick_radius;
    case (it.action)
      ACT_STORE: begin
        res.hit_category = shadow_cat;
        slot = shadow_fill[shadow_cat];
        if (slot >= POINTS_PER_CATEGORY) begin
          res.status = STS_DROPPED;
        end else begin
          shadow_points[shadow_cat][slot] = '{it.pos_x, it.pos_y, it.pos_z};
          shadow_fill[shadow_cat] = slot + 1;
          res.status    = STS_STORED;
          res.hit_index = slot[HIT_IDX_W-1:0];
        end
      end
      ACT_SET: begin
        // An unknown category code keeps the current one; screen always empties its store
        if (it.new_category <= CAT_BALL) begin
          shadow_cat = it.new_category;
          if (it.new_category == CAT_SCREEN) shadow_fill[CAT_SCREEN] = 0;
        end
        res.status       = STS_SET;
        res.hit_category = shadow_cat;
      end
      ACT_QUERY: begin
        best = r * r;
        hit  = 1'b0;
        bcat = CAT_FLOOR;
        bidx = 0;
        // Walk floor, screen, ball in index order; only a strictly closer entry wins
        for (int c = 0; c < NUM_CAT; c++) begin
          for (int i = 0; i < shadow_fill[c]; i++) begin
            ev[0]  = shadow_points[c][i].x;
            ev[1]  = shadow_points[c][i].y;
            ev[2]  = shadow_points[c][i].z;
            sum    = 0;
            reject = 1'b0;
            for (int k = 0; k < 3; k++) begin
              ad = ev[k] - qv[k];
              if (ad < 0) ad = -ad;
              if (ad >= r) reject = 1'b1;
              else sum += ad * ad;
            end
            if (!reject && sum < best) begin
              best = sum;
              hit  = 1'b1;
              bcat = c[1:0];
              bidx = i;
            end
          end
        end
        if (hit) begin
          res.status       = STS_HIT;
          res.hit_category = bcat;
          res.hit_index    = bidx[HIT_IDX_W-1:0];
          res.snap_x       = shadow_points[bcat][bidx].x;
          res.snap_y       = shadow_points[bcat][bidx].y;
          res.snap_z       = shadow_points[bcat][bidx].z;
        end else begin
          res.status = STS_MISS;
        end
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] act, input int x, input int y,
                                         input int z, input logic [FIELD_W-1:0] rad,
                                         input logic [1:0] cat);
    in_item_t it;
    it.action       = act;
    it.pos_x        = x[FIELD_W-1:0];
    it.pos_y        = y[FIELD_W-1:0];
    it.pos_z        = z[FIELD_W-1:0];
    it.pick_radius  = rad;
    it.new_category = cat;
    return it;
  endfunction

  // Mostly stores near the origin and queries near stored points, some noise
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned c;
    point_t      base;
    it.pos_x        = FIELD_W'($urandom);
    it.pos_y        = FIELD_W'($urandom);
    it.pos_z        = FIELD_W'($urandom);
    it.pick_radius  = FIELD_W'($urandom);
    it.new_category = 2'($urandom_range(0, 3));
    pick            = $urandom_range(0, 99);
    if (pick < 40) begin
      it.action = ACT_STORE;
      if ($urandom_range(0, 9) < 7) begin
        it.pos_x = FIELD_W'($urandom_range(0, 4000) - 2000);
        it.pos_y = FIELD_W'($urandom_range(0, 4000) - 2000);
        it.pos_z = FIELD_W'($urandom_range(0, 4000) - 2000);
      end
    end else if (pick < 75) begin
      it.action = ACT_QUERY;
      c = $urandom_range(0, NUM_CAT - 1);
      if (shadow_fill[c] > 0 && $urandom_range(0, 9) < 7) begin
        base     = shadow_points[c][$urandom_range(0, shadow_fill[c] - 1)];
        it.pos_x = base.x + FIELD_W'($urandom_range(0, 64) - 32);
        it.pos_y = base.y + FIELD_W'($urandom_range(0, 64) - 32);
        it.pos_z = base.z + FIELD_W'($urandom_range(0, 64) - 32);
      end
      if ($urandom_range(0, 3) != 0) it.pick_radius = FIELD_W'($urandom_range(0, 600));
    end else if (pick < 95) begin
      it.action = ACT_SET;
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then record its expected result
  task automatic send_item(input in_item_t it);
    out_item_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.payload = it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (snap_predict(it, res)) expected_results = {expected_results, res};
    @(negedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input out_item_t exp_r,
                               input out_item_t got_r);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $write("%0t %s: exp sts=%0d cat=%0d idx=%0d pt=(%0d,%0d,%0d)",
             $realtime, what, exp_r.status, exp_r.hit_category, exp_r.hit_index,
             exp_r.snap_x, exp_r.snap_y, exp_r.snap_z);
      $display(" got sts=%0d cat=%0d idx=%0d pt=(%0d,%0d,%0d)",
               got_r.status, got_r.hit_category, got_r.hit_index,
               got_r.snap_x, got_r.snap_y, got_r.snap_z);
    end
  endtask

  task automatic test_directed();
    // Query on empty stores and an action code without meaning
    send_item(make_item(ACT_QUERY, 0, 0, 0, RADIUS_MAX, CAT_FLOOR));
    send_item(make_item(ACT_NONE, 1, 2, 3, RADIUS_MAX, CAT_NONE));
    // Floor entries with extreme coordinates and a duplicated pair
    send_item(make_item(ACT_STORE, COORD_MAX, COORD_MIN, 0, 0, CAT_FLOOR));
    send_item(make_item(ACT_STORE, COORD_MIN, COORD_MAX, -1, RADIUS_MAX, CAT_NONE));
    send_item(make_item(ACT_STORE, 100, 200, 300, 0, CAT_FLOOR));
    send_item(make_item(ACT_STORE, 100, 200, 300, 0, CAT_FLOOR));
    // Tie keeps the earlier entry; zero radius and a component on the radius miss
    send_item(make_item(ACT_QUERY, 100, 200, 300, 1, CAT_FLOOR));
    send_item(make_item(ACT_QUERY, 100, 200, 300, 0, CAT_FLOOR));
    send_item(make_item(ACT_QUERY, 101, 200, 300, 1, CAT_FLOOR));
    send_item(make_item(ACT_QUERY, 0, 0, 0, RADIUS_MAX, CAT_FLOOR));
    send_item(make_item(ACT_QUERY, COORD_MIN, COORD_MAX, 0, RADIUS_MAX, CAT_FLOOR));
    // Ball store, then a category code without meaning keeps ball current
    send_item(make_item(ACT_SET, 0, 0, 0, 0, CAT_BALL));
    send_item(make_item(ACT_STORE, 110, 200, 300, 0, CAT_FLOOR));
    send_item(make_item(ACT_SET, -7, -7, -7, RADIUS_MAX, CAT_NONE));
    send_item(make_item(ACT_STORE, -5, -5, -5, 0, CAT_FLOOR));
    send_item(make_item(ACT_QUERY, 108, 200, 300, 50, CAT_FLOOR));
    // Screen store, emptied again by selecting screen while current
    send_item(make_item(ACT_SET, 0, 0, 0, 0, CAT_SCREEN));
    send_item(make_item(ACT_STORE, 105, 200, 300, 0, CAT_FLOOR));
    send_item(make_item(ACT_STORE, 7, 7, 7, 0, CAT_FLOOR));
    send_item(make_item(ACT_SET, 0, 0, 0, 0, CAT_SCREEN));
    send_item(make_item(ACT_QUERY, 105, 200, 300, 50, CAT_FLOOR));
    send_item(make_item(ACT_STORE, 9, 9, 9, 0, CAT_FLOOR));
    send_item(make_item(ACT_SET, 0, 0, 0, 0, CAT_FLOOR));
    send_item(make_item(ACT_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX, CAT_FLOOR));
  endtask

  task automatic test_random(input int n_items);
    in_item_t it;
    int       sent;
    sent = 0;
    while (sent < n_items) begin
      it = random_item();
      send_item(it);
      if (it.action != ACT_NONE) sent++;
    end
  endtask

  // Hold the result side off while items keep coming so the input stalls
  task automatic test_backpressure();
    hold_request = 300;
    repeat (16) send_item(random_item());
  endtask

  // Drive ready at the falling edge; take hold-off requests at the rising edge
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expected result
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, out_if.payload);
      end else begin
        want = expected_results.pop_front();
        if (out_if.payload.status !== want.status ||
            out_if.payload.hit_category !== want.hit_category ||
            out_if.payload.hit_index !== want.hit_index ||
            out_if.payload.snap_x !== want.snap_x ||
            out_if.payload.snap_y !== want.snap_y ||
            out_if.payload.snap_z !== want.snap_z) begin
          note_mismatch("result mismatch", want, out_if.payload);
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    mismatch_count = 0;
    hold_request   = 0;
    shadow_cat     = CAT_FLOOR;
    shadow_fill    = '{default: 0};
    src_idle_pct   = 15;
    sink_idle_pct  = 70;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(50);

    src_idle_pct  = 70;
    sink_idle_pct = 15;
    test_backpressure();
    test_random(50);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random(50);

    // Drain outstanding results, then watch for stray ones
    in_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/npss_pkg.sv
sv/npss_if.sv
sv/npss_ram.sv
sv/npss_scan.sv
sv/nearest_point_snap_store_core.sv
sv/npss_checker.sv
verif/tb_top.sv
